// ===== src/fdmp_pkg.sv =====
// Shared widths, codes, lane types and multiply helpers for the floor div/mod/pow unit
`default_nettype none
package fdmp_pkg;
    localparam int W       = 64;
    localparam int TW      = 32;
    localparam int H       = W / 2;
    localparam int FW      = 64;
    localparam int RW      = 32;

    localparam logic [1:0] FN_DIV = 2'd0;
    localparam logic [1:0] FN_MOD = 2'd1;
    localparam logic [1:0] FN_POW = 2'd2;

    typedef struct packed {
        logic         ok;
        logic         last;
        logic [1:0]   func;
        logic         sd;
        logic         na;
        logic [W-1:0] bv;
        logic [W-1:0] ub;
        logic [W-1:0] rem;
        logic [W-1:0] dq;
        logic [W-1:0] pr;
        logic [W-1:0] pb;
        logic [W-1:0] pe;
    } t_lane;

    typedef struct packed {
        logic [W-1:0]   ll;
        logic [W-H-1:0] x;
    } t_pp;

    function automatic t_pp pp_of(input logic [W-1:0] a, input logic [W-1:0] b);
        t_pp p;
        p.ll = W'(a[H-1:0]) * W'(b[H-1:0]);
        p.x  = (W-H)'(a[H-1:0]) * b[W-1:H] + a[W-1:H] * (W-H)'(b[H-1:0]);
        return p;
    endfunction

    function automatic logic [W-1:0] pp_sum(input t_pp p);
        logic [W-1:0] s;
        s = p.ll + (W'(p.x) << H);
        return s;
    endfunction
endpackage
`default_nettype wire

// ===== src/fdmp_if.sv =====
// Row and result channels of the floor div/mod/pow unit
`default_nettype none
interface fdmp_row_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [63:0] left_value;
    logic        left_present;
    logic [63:0] right_value;
    logic        right_present;
    logic        row_is_last;
    modport source (output valid, func, left_value, left_present, right_value,
                    right_present, row_is_last, input ready);
    modport sink (input valid, func, left_value, left_present, right_value,
                  right_present, row_is_last, output ready);
endinterface

interface fdmp_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_value;
    logic        result_present;
    logic [31:0] nulls_in_column;
    logic        result_is_last;
    modport source (output valid, result_value, result_present, nulls_in_column,
                    result_is_last, input ready);
    modport sink (input valid, result_value, result_present, nulls_in_column,
                  result_is_last, output ready);
endinterface
`default_nettype wire

// ===== src/floor_div_mod_pow_int64_unit.sv =====
// Top level: operand prep, bit-step pipeline, floor fix-up, null tally and result register
// Path from row accepted to result shown: prep register, two stages per bit, output register.
// Throughput: one row per cycle; the whole pipeline holds while a shown result is not taken.
// Each of the 64 bit steps holds one divide subtract and the two split multiplies of power.
// Reset: synchronous, active low; clears all valid bits and the null tally.
`default_nettype none
module floor_div_mod_pow_int64_unit import fdmp_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    fdmp_row_if.sink    i_row,
    fdmp_res_if.source  o_res
);
    logic         en;
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic         b_nz;
    t_lane        n_p;
    t_lane        r_p;
    logic         r_pv;
    logic         s_v [W+1];
    t_lane        s_lane [W+1];
    t_lane        fl;
    logic [W-1:0] q;
    logic [W-1:0] r;
    logic [W-1:0] val;
    logic [TW-1:0] n_tally;
    logic [TW-1:0] r_tally;
    logic [63:0]  tz;
    logic         r_out_valid;
    logic [FW-1:0] r_value;
    logic         r_present;
    logic [RW-1:0] r_nulls;
    logic         r_last;

    assign en          = ~r_out_valid | o_res.ready;
    assign i_row.ready = en;

    always_comb begin
        a      = i_row.left_value[W-1:0];
        b      = i_row.right_value[W-1:0];
        b_nz   = (b != '0);
        n_p    = '0;
        n_p.ok = i_row.left_present & i_row.right_present &
                 (((i_row.func == FN_DIV) & b_nz) | ((i_row.func == FN_MOD) & b_nz) |
                  ((i_row.func == FN_POW) & ~b[W-1]));
        n_p.last = i_row.row_is_last;
        n_p.func = i_row.func;
        n_p.sd   = a[W-1] ^ b[W-1];
        n_p.na   = a[W-1];
        n_p.bv   = b;
        n_p.ub   = b[W-1] ? -b : b;
        n_p.rem  = '0;
        n_p.dq   = a[W-1] ? -a : a;
        n_p.pr   = W'(1);
        n_p.pb   = a;
        n_p.pe   = b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (en) begin
            r_pv <= i_row.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p <= n_p;
        end
    end

    assign s_v[0]    = r_pv;
    assign s_lane[0] = r_p;

    for (genvar k = 0; k < W; k++) begin : g_step
        fdmp_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (s_v[k]),
            .i_lane  (s_lane[k]),
            .o_valid (s_v[k+1]),
            .o_lane  (s_lane[k+1])
        );
    end

    always_comb begin
        fl = s_lane[W];
        if (!fl.sd) begin
            q = fl.dq;
        end else if (fl.rem != '0) begin
            q = ~fl.dq;
        end else begin
            q = -fl.dq;
        end
        if (fl.rem == '0) begin
            r = '0;
        end else if (fl.na) begin
            r = fl.sd ? fl.bv - fl.rem : -fl.rem;
        end else begin
            r = fl.sd ? fl.rem + fl.bv : fl.rem;
        end
        case (fl.func)
            FN_DIV:  val = q;
            FN_MOD:  val = r;
            default: val = fl.pr;
        endcase
        if (fl.ok || (r_tally == '1)) begin
            n_tally = r_tally;
        end else begin
            n_tally = r_tally + TW'(1);
        end
        tz = 64'(n_tally);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_tally     <= '0;
        end else if (en) begin
            r_out_valid <= s_v[W];
            if (s_v[W]) begin
                r_tally <= fl.last ? '0 : n_tally;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_value   <= fl.ok ? FW'($signed(val)) : '0;
            r_present <= fl.ok;
            r_nulls   <= (tz > 64'hFFFF_FFFF) ? '1 : tz[RW-1:0];
            r_last    <= fl.last;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.result_value    = r_value;
    assign o_res.result_present  = r_present;
    assign o_res.nulls_in_column = r_nulls;
    assign o_res.result_is_last  = r_last;

    a_null_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.result_present |-> o_res.result_value == '0)
        else $error("null result carries a value");
    a_null_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.result_present |-> o_res.nulls_in_column != '0)
        else $error("null result not counted");
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_res.valid)
        else $error("result shown after reset");
endmodule
`default_nettype wire

// ===== src/fdmp_step.sv =====
// One bit step: divide step and multiply partials, then power sums, two register stages
`default_nettype none
module fdmp_step import fdmp_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_valid,
    input  wire t_lane i_lane,
    output logic       o_valid,
    output t_lane      o_lane
);
    logic [W:0]   rem_sh;
    logic [W+1:0] diff;
    logic         ge;
    t_lane        n_la;
    t_lane        r_la;
    t_lane        n_lb;
    t_lane        r_lb;
    t_pp          r_ppr;
    t_pp          r_ppb;
    logic         r_e0;
    logic         r_va;
    logic         r_vb;

    always_comb begin
        rem_sh    = {i_lane.rem, i_lane.dq[W-1]};
        diff      = {1'b0, rem_sh} - {2'b00, i_lane.ub};
        ge        = ~diff[W+1];
        n_la      = i_lane;
        n_la.rem  = ge ? diff[W-1:0] : rem_sh[W-1:0];
        n_la.dq   = {i_lane.dq[W-2:0], ge};
    end

    always_comb begin
        n_lb    = r_la;
        n_lb.pr = r_e0 ? pp_sum(r_ppr) : r_la.pr;
        n_lb.pb = pp_sum(r_ppb);
        n_lb.pe = r_la.pe >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_la  <= n_la;
            r_e0  <= i_lane.pe[0];
            r_ppr <= pp_of(i_lane.pr, i_lane.pb);
            r_ppb <= pp_of(i_lane.pb, i_lane.pb);
            r_lb  <= n_lb;
        end
    end

    assign o_valid = r_vb;
    assign o_lane  = r_lb;
endmodule
`default_nettype wire
